FILE: rtl/mict_pkg.sv
// Package: shared types, codes and default sizes of the multiset intersection table.
`default_nettype none
package mict_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int COUNT_BITS_DEF    = 16;
	localparam int VALUE_BITS_DEF    = 32;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_PROBE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_LOADED  = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_MATCH   = 3'd2;
	localparam logic [2:0] ST_NOMATCH = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} mict_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] echo_value;
		logic [15:0]        remaining;
	} mict_out_t;

endpackage
`default_nettype wire

FILE: rtl/mict_front.sv
// Front end: accepts items, drops unused op codes, queues commands two deep.
`default_nettype none
module mict_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mict_pkg::mict_in_t in_data,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output mict_pkg::mict_in_t     cmd
);

	mict_pkg::mict_in_t q_mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               pop;
	logic               known_op;

	// classify: op code three is taken and dropped
	assign known_op = (in_data.op == mict_pkg::OP_LOAD) || (in_data.op == mict_pkg::OP_PROBE)
		|| (in_data.op == mict_pkg::OP_CLEAR);
	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready && known_op;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	// hold queued payload
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue fill count out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/mict_back.sv
// Back end: associative key/count table, compare then update, result register.
`default_nettype none
module mict_back #(
	parameter int TABLE_ENTRIES = mict_pkg::TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS    = mict_pkg::COUNT_BITS_DEF,
	parameter int VALUE_BITS    = mict_pkg::VALUE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire mict_pkg::mict_in_t cmd,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mict_pkg::mict_out_t     out_data
);

	typedef enum logic [1:0] {
		S_CMP = 2'b01,
		S_UPD = 2'b10
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   key_q [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0]   cnt_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;

	logic [VALUE_BITS-1:0]   head_key;
	logic [TABLE_ENTRIES-1:0] hit_c;
	logic [TABLE_ENTRIES-1:0] free_c;
	logic [TABLE_ENTRIES-1:0] hit_s1;
	logic [TABLE_ENTRIES-1:0] ffree_s1;
	logic [VALUE_BITS-1:0]   key_s1;
	mict_pkg::mict_in_t      cmd_s1;

	logic                    take;
	logic                    upd_fire;
	logic                    any_hit;
	logic                    any_free;
	logic [COUNT_BITS-1:0]   sel_cnt;
	logic [COUNT_BITS-1:0]   new_cnt;
	logic [15:0]             shown;
	mict_pkg::mict_out_t     res_c;
	mict_pkg::mict_out_t     out_q;
	logic                    out_v_q;

	// form the key from the value: sign-extended when wider than 32 bits, else truncated
	generate
		if (VALUE_BITS > 32) begin : g_key_ext
			assign head_key = {{(VALUE_BITS-32){cmd.value[31]}}, cmd.value};
		end else begin : g_key_cut
			assign head_key = cmd.value[VALUE_BITS-1:0];
		end
	endgenerate

	// broadcast compare and lowest free entry
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_c[i] = vld_q[i] && (key_q[i] == head_key);
		end
	end
	assign free_c = ~vld_q & (vld_q + TABLE_ENTRIES'(1));

	assign cmd_ready = (state_q == S_CMP);
	assign take      = cmd_valid && cmd_ready;
	assign upd_fire  = (state_q == S_UPD) && (!out_v_q || out_ready);

	// compare stage register
	always_ff @(posedge clk) begin
		if (take) begin
			hit_s1   <= hit_c;
			ffree_s1 <= free_c;
			key_s1   <= head_key;
			cmd_s1   <= cmd;
		end
	end

	// select the count of the hit entry
	always_comb begin
		sel_cnt = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sel_cnt = sel_cnt | (hit_s1[i] ? cnt_q[i] : '0);
		end
	end
	assign any_hit  = |hit_s1;
	assign any_free = |ffree_s1;

	always_comb begin
		if (cmd_s1.op == mict_pkg::OP_LOAD) begin
			new_cnt = (sel_cnt == '1) ? sel_cnt : sel_cnt + COUNT_BITS'(1);
		end else begin
			new_cnt = (sel_cnt == '0) ? sel_cnt : sel_cnt - COUNT_BITS'(1);
		end
	end

	// clamp the reported count to sixteen bits
	generate
		if (COUNT_BITS > 16) begin : g_rem_sat
			assign shown = (|new_cnt[COUNT_BITS-1:16]) ? 16'hFFFF : new_cnt[15:0];
		end else begin : g_rem_ext
			assign shown = 16'(new_cnt);
		end
	endgenerate

	// build the result
	always_comb begin
		res_c.status     = mict_pkg::ST_CLEARED;
		res_c.echo_value = '0;
		res_c.remaining  = '0;
		case (cmd_s1.op)
			mict_pkg::OP_LOAD: begin
				if (any_hit) begin
					res_c.status    = mict_pkg::ST_LOADED;
					res_c.remaining = shown;
				end else if (any_free) begin
					res_c.status    = mict_pkg::ST_LOADED;
					res_c.remaining = 16'd1;
				end else begin
					res_c.status = mict_pkg::ST_FULL;
				end
			end
			mict_pkg::OP_PROBE: begin
				if (any_hit) begin
					res_c.status     = mict_pkg::ST_MATCH;
					res_c.echo_value = cmd_s1.value;
					res_c.remaining  = shown;
				end else begin
					res_c.status = mict_pkg::ST_NOMATCH;
				end
			end
			default: begin
				res_c.status = mict_pkg::ST_CLEARED;
			end
		endcase
	end

	// write keys of newly allocated entries
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (upd_fire && cmd_s1.op == mict_pkg::OP_LOAD && !any_hit && ffree_s1[i]) begin
				key_q[i] <= key_s1;
			end
		end
	end

	// update counts and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) cnt_q[i] <= '0;
		end else if (upd_fire) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				case (cmd_s1.op)
					mict_pkg::OP_LOAD: begin
						if (hit_s1[i]) begin
							cnt_q[i] <= new_cnt;
						end else if (!any_hit && ffree_s1[i]) begin
							cnt_q[i] <= COUNT_BITS'(1);
							vld_q[i] <= 1'b1;
						end
					end
					mict_pkg::OP_PROBE: begin
						if (hit_s1[i]) begin
							cnt_q[i] <= new_cnt;
							if (new_cnt == '0) vld_q[i] <= 1'b0;
						end
					end
					default: begin
						cnt_q[i] <= '0;
						vld_q[i] <= 1'b0;
					end
				endcase
			end
		end
	end

	// sequence compare and update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CMP;
		end else begin
			unique case (state_q)
				S_CMP: if (take) state_q <= S_UPD;
				S_UPD: if (upd_fire) state_q <= S_CMP;
				default: state_q <= S_CMP;
			endcase
		end
	end

	// hold the result until transfer
	always_ff @(posedge clk) begin
		if (upd_fire) out_q <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (upd_fire) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $onehot0(hit_s1))
		else $error("key present in more than one entry");
	a_free_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $onehot0(ffree_s1))
		else $error("more than one free entry selected");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && cmd_s1.op == mict_pkg::OP_CLEAR) |=> (vld_q == '0))
		else $error("table not empty after clear");
	a_no_take_upd: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> (out_v_q && state_q == S_CMP))
		else $error("result not registered after update");
`endif

endmodule
`default_nettype wire

FILE: rtl/multiset_intersection_count_table.sv
// Top level: multiset intersection engine over an associative key/count table.
// Each item is registered in the command queue, whose head feeds the broadcast compare, then in
// the compare stage register while the update runs, and its result goes to the result register.
// The table takes a new command only after the update of the last one; a full output stalls the update.
// Reset (arst_n low, asynchronous) empties the table and the queue; keys hold no reset.
`default_nettype none
module multiset_intersection_count_table #(
	parameter int TABLE_ENTRIES = mict_pkg::TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS    = mict_pkg::COUNT_BITS_DEF,
	parameter int VALUE_BITS    = mict_pkg::VALUE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mict_pkg::mict_in_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mict_pkg::mict_out_t     out_data
);

	logic               cmd_valid;
	logic               cmd_ready;
	mict_pkg::mict_in_t cmd;

	mict_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	mict_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COUNT_BITS    (COUNT_BITS),
		.VALUE_BITS    (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
